// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ----- rtl/md4_pkg.sv -----
// ----------------------------------------------------------------------------
// MD4 engine package
// Constants, request codes, state types and step helper functions.
// ----------------------------------------------------------------------------
package md4_pkg;

  localparam logic [31:0] IV_A     = 32'h67452301;
  localparam logic [31:0] IV_B     = 32'hefcdab89;
  localparam logic [31:0] IV_C     = 32'h98badcfe;
  localparam logic [31:0] IV_D     = 32'h10325476;
  localparam logic [31:0] K_ROUND2 = 32'h5a827999;
  localparam logic [31:0] K_ROUND3 = 32'h6ed9eba1;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  localparam logic [3:0][31:0] IV_WORDS = {IV_D, IV_C, IV_B, IV_A};

  localparam int unsigned CNT_W   = 61;  // message length in bytes, modulo 2^61
  localparam int unsigned WORDS   = 16;
  localparam int unsigned WADDR_W = 4;
  localparam logic [5:0]  LAST_STEP = 6'd47;

  localparam logic [1:0] REQ_ABSORB = 2'd0;
  localparam logic [1:0] REQ_FINISH = 2'd1;
  localparam logic [1:0] REQ_PEEK   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MSG,
    ST_PAD1,
    ST_PAD2,
    ST_EMIT
  } top_state_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_RUN,
    C_ADD
  } core_state_t;

  // Where the sixteen words of a block come from.
  typedef enum logic [1:0] {
    BLK_MSG,       // all words from the block store
    BLK_PAD_LEN,   // stored words, pad word, zeros, bit length
    BLK_PAD_ONLY,  // stored words, pad word, zeros
    BLK_LEN_ONLY   // zeros and bit length
  } blk_kind_t;

  typedef struct packed {
    logic      start;
    logic      keep_h;
    blk_kind_t kind;
  } core_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  typedef struct packed {
    logic [WADDR_W-1:0] fw;
    logic [31:0]        pad_word;
    logic [63:0]        bit_len;
  } pad_info_t;

  // Message word used by a step: rounds two and three permute the index.
  function automatic logic [WADDR_W-1:0] word_index(input logic [5:0] step);
    logic [3:0] k;
    k = step[3:0];
    case (step[5:4])
      2'd1:    return {k[1:0], k[3:2]};
      2'd2:    return {k[0], k[1], k[2], k[3]};
      default: return k;
    endcase
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] step);
    logic [4:0] s;
    case ({step[5:4], step[1:0]})
      4'b0000: s = 5'd3;
      4'b0001: s = 5'd7;
      4'b0010: s = 5'd11;
      4'b0011: s = 5'd19;
      4'b0100: s = 5'd3;
      4'b0101: s = 5'd5;
      4'b0110: s = 5'd9;
      4'b0111: s = 5'd13;
      4'b1000: s = 5'd3;
      4'b1001: s = 5'd9;
      4'b1010: s = 5'd11;
      4'b1011: s = 5'd15;
      default: s = 5'd3;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] t;
    t = {v, v} << n;
    return t[63:32];
  endfunction

endpackage

// ----- rtl/md4_hash_engine.sv -----
// ----------------------------------------------------------------------------
// MD4 hash engine
// Streaming MD4 digest: absorbs bytes, emits digests on peek and finish.
// ----------------------------------------------------------------------------
// Absorb transactions are taken one per cycle while the engine is idle; the byte
// that fills a block holds in_tready low while the 48-step core runs on the store.
// A peek or finish compresses one padded block before its digest is offered, or two
// when the padding spills into a second block (message length mod 64 >= 56).
// Synchronous active-low reset loads the initial chaining words and clears the
// byte count; the block store RAM is not cleared and needs no clearing pass.
module md4_hash_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [15:0]   in_tdata,   // [1:0] req_type, [9:2] msg_byte, rest zero
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [127:0]  out_tdata   // [63:0] digest_low, [127:64] digest_high
);

`include "assert_macros.svh"

  md4_pkg::top_state_t state_r, state_nxt;
  logic [3:0][31:0]          chain_r;
  logic [md4_pkg::CNT_W-1:0] cnt_r;
  logic [31:0]               part_r, part_nxt;
  logic                      fin_r;
  logic                      out_valid_r;
  logic [127:0]              out_data_r;

  logic [1:0]  req;
  logic [7:0]  msg_byte;
  logic        accept, absorb, digest_req, block_full, two_blocks, emit_go;
  logic        ram_we;
  logic [31:0] ram_wdata, ram_rdata;
  logic [md4_pkg::WADDR_W-1:0] ram_raddr;

  md4_pkg::core_ctl_t  core_ctl;
  md4_pkg::core_stat_t core_stat;
  md4_pkg::pad_info_t  pad;
  logic [3:0][31:0]    hash;

  assign req        = in_tdata[1:0];
  assign msg_byte   = in_tdata[9:2];
  assign in_tready  = (state_r == md4_pkg::ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign absorb     = accept && (req == md4_pkg::REQ_ABSORB);
  assign digest_req = accept && (req == md4_pkg::REQ_FINISH || req == md4_pkg::REQ_PEEK);
  assign block_full = (cnt_r[5:0] == 6'd63);
  assign two_blocks = (cnt_r[5:3] == 3'b111);
  assign emit_go    = (state_r == md4_pkg::ST_EMIT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      md4_pkg::ST_IDLE: begin
        if (absorb && block_full) begin
          state_nxt = md4_pkg::ST_MSG;
        end else if (digest_req) begin
          state_nxt = two_blocks ? md4_pkg::ST_PAD1 : md4_pkg::ST_PAD2;
        end
      end
      md4_pkg::ST_MSG:  if (core_stat.done) state_nxt = md4_pkg::ST_IDLE;
      md4_pkg::ST_PAD1: if (core_stat.done) state_nxt = md4_pkg::ST_PAD2;
      md4_pkg::ST_PAD2: if (core_stat.done) state_nxt = md4_pkg::ST_EMIT;
      md4_pkg::ST_EMIT: if (emit_go) state_nxt = md4_pkg::ST_IDLE;
      default:          state_nxt = md4_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    core_ctl.start  = 1'b0;
    core_ctl.keep_h = 1'b0;
    core_ctl.kind   = md4_pkg::BLK_MSG;
    if (absorb && block_full) begin
      core_ctl.start = 1'b1;
    end else if (digest_req) begin
      core_ctl.start = 1'b1;
      core_ctl.kind  = two_blocks ? md4_pkg::BLK_PAD_ONLY : md4_pkg::BLK_PAD_LEN;
    end else if (state_r == md4_pkg::ST_PAD1 && core_stat.done) begin
      core_ctl.start  = 1'b1;
      core_ctl.keep_h = 1'b1;
      core_ctl.kind   = md4_pkg::BLK_LEN_ONLY;
    end
  end

  // Bytes of the current word gather in part_r; a full word goes to the RAM.
  always_comb begin
    part_nxt = part_r;
    part_nxt[8*cnt_r[1:0] +: 8] = msg_byte;
    ram_we    = absorb && (cnt_r[1:0] == 2'd3);
    ram_wdata = {msg_byte, part_r[23:0]};
  end

  // Pad word: bytes already held, then 0x80, then zeros.
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      if (2'(b) < cnt_r[1:0]) begin
        pad.pad_word[8*b +: 8] = part_r[8*b +: 8];
      end else if (2'(b) == cnt_r[1:0]) begin
        pad.pad_word[8*b +: 8] = md4_pkg::PAD_BYTE;
      end else begin
        pad.pad_word[8*b +: 8] = 8'd0;
      end
    end
    pad.fw      = cnt_r[5:2];
    pad.bit_len = {cnt_r, 3'b000};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= md4_pkg::ST_IDLE;
      chain_r     <= md4_pkg::IV_WORDS;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (absorb) begin
        cnt_r <= md4_pkg::CNT_W'(cnt_r + 1'b1);
      end
      if (state_r == md4_pkg::ST_MSG && core_stat.done) begin
        chain_r <= hash;
      end
      if (emit_go && fin_r) begin
        chain_r <= md4_pkg::IV_WORDS;
        cnt_r   <= '0;
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (absorb) begin
      part_r <= part_nxt;
    end
    if (digest_req) begin
      fin_r <= (req == md4_pkg::REQ_FINISH);
    end
    if (emit_go) begin
      out_data_r <= {hash[3], hash[2], hash[1], hash[0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  md4_ram #(
    .WIDTH(32),
    .DEPTH(md4_pkg::WORDS)
  ) u_block_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[5:2]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  md4_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (core_ctl),
    .pad       (pad),
    .base      (chain_r),
    .ram_rdata (ram_rdata),
    .ram_raddr (ram_raddr),
    .stat      (core_stat),
    .hash      (hash)
  );

  // The core reports completion only to a state that waits for it.
  `ASSERT_PROP(a_done_expected, clk, rst_n, core_stat.done |-> (state_r == md4_pkg::ST_MSG || state_r == md4_pkg::ST_PAD1 || state_r == md4_pkg::ST_PAD2))
  // A new block never starts while the core is still working.
  `ASSERT_NEVER(a_start_busy, clk, rst_n, core_ctl.start && core_stat.busy)
  // The block store is not written under a running compression.
  `ASSERT_NEVER(a_write_busy, clk, rst_n, ram_we && core_stat.busy)
  // A result appears only out of the emit state.
  `ASSERT_PROP(a_emit_src, clk, rst_n, $rose(out_tvalid) |-> $past(state_r == md4_pkg::ST_EMIT))

endmodule

// ----- rtl/md4_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with a registered read.
// ----------------------------------------------------------------------------
module md4_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/md4_core.sv -----
// ----------------------------------------------------------------------------
// MD4 compression core
// Runs the 48 steps of one block, one step a cycle, reading message words
// from the block store and substituting padding and length words as needed.
// ----------------------------------------------------------------------------
module md4_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  md4_pkg::core_ctl_t           ctl,
  input  md4_pkg::pad_info_t           pad,
  input  logic [3:0][31:0]             base,
  input  logic [31:0]                  ram_rdata,
  output logic [md4_pkg::WADDR_W-1:0]  ram_raddr,
  output md4_pkg::core_stat_t          stat,
  output logic [3:0][31:0]             hash
);

  md4_pkg::core_state_t state_r, state_nxt;
  md4_pkg::blk_kind_t   kind_r;
  logic [5:0]           step_r;
  logic                 done_r;
  logic [3:0][31:0]     r_r, r_nxt;
  logic [3:0][31:0]     h_r;

  logic [md4_pkg::WADDR_W-1:0] j;
  logic [31:0] w, f, k, sum;
  logic [5:0]  issue_step;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      md4_pkg::C_IDLE: if (ctl.start) state_nxt = md4_pkg::C_RUN;
      md4_pkg::C_RUN:  if (step_r == md4_pkg::LAST_STEP) state_nxt = md4_pkg::C_ADD;
      md4_pkg::C_ADD:  state_nxt = md4_pkg::C_IDLE;
      default:         state_nxt = md4_pkg::C_IDLE;
    endcase
  end

  // The read for the next step is issued in the cycle before its use.
  always_comb begin
    issue_step = ctl.start ? 6'd0 : 6'(step_r + 6'd1);
    ram_raddr  = md4_pkg::word_index(issue_step);
    stat.busy  = (state_r != md4_pkg::C_IDLE);
    stat.done  = done_r;
    hash       = h_r;
  end

  always_comb begin
    j = md4_pkg::word_index(step_r);
    w = 32'd0;
    case (kind_r)
      md4_pkg::BLK_MSG: w = ram_rdata;
      md4_pkg::BLK_PAD_LEN, md4_pkg::BLK_PAD_ONLY: begin
        if (j < pad.fw) begin
          w = ram_rdata;
        end else if (j == pad.fw) begin
          w = pad.pad_word;
        end else if (kind_r == md4_pkg::BLK_PAD_LEN && j == 4'd14) begin
          w = pad.bit_len[31:0];
        end else if (kind_r == md4_pkg::BLK_PAD_LEN && j == 4'd15) begin
          w = pad.bit_len[63:32];
        end
      end
      default: begin
        if (j == 4'd14) begin
          w = pad.bit_len[31:0];
        end else if (j == 4'd15) begin
          w = pad.bit_len[63:32];
        end
      end
    endcase
  end

  // Register roles rotate each step: a is replaced, then the four shift along.
  always_comb begin
    case (step_r[5:4])
      2'd0: begin
        f = (r_r[1] & r_r[2]) | (~r_r[1] & r_r[3]);
        k = 32'd0;
      end
      2'd1: begin
        f = (r_r[1] & r_r[2]) | (r_r[1] & r_r[3]) | (r_r[2] & r_r[3]);
        k = md4_pkg::K_ROUND2;
      end
      default: begin
        f = r_r[1] ^ r_r[2] ^ r_r[3];
        k = md4_pkg::K_ROUND3;
      end
    endcase
    sum      = r_r[0] + f + w + k;
    r_nxt[0] = r_r[3];
    r_nxt[1] = md4_pkg::rotl32(sum, md4_pkg::rot_amount(step_r));
    r_nxt[2] = r_r[1];
    r_nxt[3] = r_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= md4_pkg::C_IDLE;
      step_r  <= 6'd0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == md4_pkg::C_ADD);
      if (ctl.start) begin
        step_r <= 6'd0;
      end else if (state_r == md4_pkg::C_RUN) begin
        step_r <= 6'(step_r + 6'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      kind_r <= ctl.kind;
      if (ctl.keep_h) begin
        r_r <= h_r;
      end else begin
        r_r <= base;
        h_r <= base;
      end
    end else if (state_r == md4_pkg::C_RUN) begin
      r_r <= r_nxt;
    end else if (state_r == md4_pkg::C_ADD) begin
      for (int i = 0; i < 4; i++) begin
        h_r[i] <= h_r[i] + r_r[i];
      end
    end
  end

endmodule

// ----- tb/tb_md4_hash_engine.sv -----
// ----------------------------------------------------------------------------
// MD4 hash engine testbench
// Streams absorb, peek and finish transactions with random gaps and
// backpressure into the engine. A predictor inside a small scoreboard class
// computes each expected digest, and every output transaction is compared
// with the oldest expected one.
// ----------------------------------------------------------------------------
module tb_md4_hash_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]   REQ_UNUSED   = 2'd3;
  localparam logic [31:0]  ROUND2_ADD   = 32'h5a827999;
  localparam logic [31:0]  ROUND3_ADD   = 32'h6ed9eba1;
  localparam logic [127:0] START_CHAIN  = {32'h10325476, 32'h98badcfe,
                                           32'hefcdab89, 32'h67452301};
  localparam logic [7:0]   MARKER_BYTE  = 8'h80;
  // Digest of the empty message, bytes packed as on out_tdata.
  localparam logic [127:0] EMPTY_DIGEST = {64'hc089c0e0d7593cb7,
                                           64'h31e96ad1e0cfd631};
  localparam int           HOLD_CYCLES  = 400;
  localparam int           DRAIN_CYCLES = 120;
  localparam int           TOTAL_REQS   = 1365;
  localparam int           CALM_REQS    = 1215;

  class md4_digest_tracker;
    logic [3:0][31:0] chain;
    logic [63:0][7:0] store;
    logic [5:0]       fill;
    logic [63:0]      bit_count;
    logic [127:0]     digests_due[$];
    int               mismatches;

    function new();
      mismatches = 0;
      clear_message();
    endfunction

    function void clear_message();
      chain     = START_CHAIN;
      store     = '0;
      fill      = '0;
      bit_count = '0;
    endfunction

    function logic [3:0][31:0] compress_block(logic [3:0][31:0] cw, logic [63:0][7:0] blk);
      logic [31:0]      w [16];
      logic [3:0][31:0] r;
      logic [31:0]      x, y, z, mix, sum;
      int               a, k, idx, s;
      int               rot_tab [12] = '{3, 7, 11, 19, 3, 5, 9, 13, 3, 9, 11, 15};
      for (int i = 0; i < 16; i++) begin
        w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
      end
      r = cw;
      for (int st = 0; st < 48; st++) begin
        // The updated word walks backwards through a, d, c, b.
        a = (4 - st % 4) % 4;
        x = r[(a + 1) % 4];
        y = r[(a + 2) % 4];
        z = r[(a + 3) % 4];
        k = st % 16;
        case (st / 16)
          0: begin
            mix = (x & y) | (~x & z);
            idx = k;
          end
          1: begin
            mix = ((x & y) | (x & z) | (y & z)) + ROUND2_ADD;
            idx = (k % 4) * 4 + k / 4;
          end
          default: begin
            mix = (x ^ y ^ z) + ROUND3_ADD;
            idx = {k[0], k[1], k[2], k[3]};
          end
        endcase
        s    = rot_tab[(st / 16) * 4 + st % 4];
        sum  = r[a] + mix + w[idx];
        r[a] = (sum << s) | (sum >> (32 - s));
      end
      for (int i = 0; i < 4; i++) begin
        r[i] = r[i] + cw[i];
      end
      return r;
    endfunction

    // Pads a copy of the current message and finishes it.
    function logic [127:0] predict_digest();
      logic [63:0][7:0] blk;
      logic [3:0][31:0] cw;
      int               pos;
      blk = store;
      cw  = chain;
      pos = fill;
      blk[pos] = MARKER_BYTE;
      pos++;
      if (pos > 56) begin
        for (int j = pos; j < 64; j++) blk[j] = 8'h00;
        cw  = compress_block(cw, blk);
        pos = 0;
      end
      for (int j = pos; j < 56; j++) blk[j] = 8'h00;
      for (int j = 0; j < 8; j++) blk[56+j] = bit_count[8*j +: 8];
      cw = compress_block(cw, blk);
      return cw;
    endfunction

    function void note_request(logic [1:0] code, logic [7:0] value);
      case (code)
        md4_pkg::REQ_ABSORB: begin
          store[fill] = value;
          fill        = fill + 6'd1;
          if (fill == 6'd0) chain = compress_block(chain, store);
          bit_count   = bit_count + 64'd8;
        end
        md4_pkg::REQ_FINISH: begin
          digests_due.push_back(predict_digest());
          clear_message();
        end
        md4_pkg::REQ_PEEK: begin
          digests_due.push_back(predict_digest());
        end
        default: ;
      endcase
    endfunction

    function void check_digest(logic [127:0] got);
      logic [127:0] want;
      if (digests_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("digest %h arrived with none expected", got);
        return;
      end
      want = digests_due.pop_front();
      for (int h = 0; h < 2; h++) begin
        if (got[64*h +: 64] !== want[64*h +: 64]) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%s mismatch: expected %h, got %h",
                     h ? "digest_high" : "digest_low", want[64*h +: 64], got[64*h +: 64]);
          end
        end
      end
    endfunction

    function int pending();
      return digests_due.size();
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [15:0]  in_tdata = '0;    // [1:0] req_type, [9:2] msg_byte, rest zero
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;        // [63:0] digest_low, [127:64] digest_high

  md4_digest_tracker digests;
  bit                calm = 1'b0;
  bit                hold_off = 1'b0;
  int                requests_sent = 0;

  md4_hash_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("tb_md4_hash_engine failed");
    $finish;
  end

  // Sends one request, sometimes after a random gap, and waits for its transaction.
  task automatic send_request(input logic [1:0] code, input logic [7:0] value);
    if (!calm && $urandom_range(0, 6) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, value, code};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    digests.note_request(code, value);
    if (code != REQ_UNUSED) requests_sent++;
    if (requests_sent >= CALM_REQS) calm = 1'b1;
  endtask

  task automatic send_message(input int len);
    for (int b = 0; b < len; b++) begin
      if ($urandom_range(0, 23) == 0) begin
        send_request(md4_pkg::REQ_PEEK, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 39) == 0) send_request(REQ_UNUSED, 8'($urandom_range(0, 255)));
      send_request(md4_pkg::REQ_ABSORB, 8'($urandom_range(0, 255)));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) digests.check_digest(out_tdata);
  end

  // Result side: random stalls, plus one long hold-off when the stimulus asks for it.
  initial begin
    forever begin
      if (hold_off) begin
        hold_off = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    int len;
    int msg_count;
    digests = new();
    if (digests.predict_digest() !== EMPTY_DIGEST) begin
      digests.mismatches++;
      $display("predictor gives %h for the empty message", digests.predict_digest());
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty message, ignored code, short messages, byte extremes.
    send_request(md4_pkg::REQ_FINISH, 8'h00);
    send_request(md4_pkg::REQ_PEEK, 8'hff);
    send_request(REQ_UNUSED, 8'hff);
    send_request(md4_pkg::REQ_ABSORB, 8'h61);
    send_request(md4_pkg::REQ_ABSORB, 8'h62);
    send_request(md4_pkg::REQ_ABSORB, 8'h63);
    send_request(md4_pkg::REQ_PEEK, 8'h00);
    send_request(REQ_UNUSED, 8'h00);
    send_request(md4_pkg::REQ_FINISH, 8'hff);
    send_request(md4_pkg::REQ_ABSORB, 8'h00);
    send_request(md4_pkg::REQ_ABSORB, 8'hff);
    send_request(md4_pkg::REQ_PEEK, 8'h55);
    send_request(md4_pkg::REQ_ABSORB, 8'haa);
    send_request(md4_pkg::REQ_FINISH, 8'h00);
    send_request(md4_pkg::REQ_PEEK, 8'h00);

    // Random messages, weighted toward the lengths where padding spills over.
    msg_count = 0;
    while (requests_sent < TOTAL_REQS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: len = $urandom_range(0, 12);
        3, 4, 5: len = $urandom_range(50, 70);
        6, 7:    len = $urandom_range(0, 140);
        8:       len = $urandom_range(112, 135);
        default: len = $urandom_range(0, 3) * 64 + $urandom_range(54, 57);
      endcase
      send_message(len);
      if (msg_count == 4 || msg_count == 15) begin
        // The receiver holds off while peeks keep coming, so the engine backs up.
        hold_off = 1'b1;
        repeat (8) send_request(md4_pkg::REQ_PEEK, 8'($urandom_range(0, 255)));
      end
      if (msg_count == 9 || msg_count == 20) begin
        in_tvalid <= 1'b0;
        while (digests.pending() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 7) != 0) begin
        send_request(md4_pkg::REQ_FINISH, 8'($urandom_range(0, 255)));
      end else begin
        send_request(md4_pkg::REQ_PEEK, 8'($urandom_range(0, 255)));
      end
      msg_count++;
    end
    send_request(md4_pkg::REQ_FINISH, 8'h00);
    in_tvalid <= 1'b0;

    while (digests.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (digests.mismatches == 0 && digests.pending() == 0) begin
      $display("tb_md4_hash_engine passed");
    end else begin
      $display("tb_md4_hash_engine failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/md4_pkg.sv
rtl/md4_ram.sv
rtl/md4_core.sv
rtl/md4_hash_engine.sv
tb/tb_md4_hash_engine.sv
